[rtl/core/cfa_pkg.sv]
// Shared constants and the sequencer state type of the continued-fraction approximator.
`timescale 1ns / 1ps

package cfa_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int VALUE_BITS = 32;
    localparam int TOL_W      = 16;
    localparam int NUM_W      = 33;
    localparam int DEN_W      = 17;

    localparam int IP_W   = VALUE_BITS - FRAC_BITS;   // whole part of the magnitude
    localparam int FR_W   = FRAC_BITS;                // fraction part of the magnitude
    localparam int DBITS  = FRAC_BITS + 1;            // denominators, terms, 2^FRAC_BITS
    localparam int NUMI_W = VALUE_BITS + 1;           // internal numerator magnitude

    localparam int MUL_A  = (DBITS > IP_W) ? DBITS : IP_W;
    localparam int MUL_W  = (MUL_A > TOL_W) ? MUL_A : TOL_W;
    localparam int PROD_W = 2 * MUL_W;

    localparam int DIV_STEPS = DBITS;
    localparam int CNT_W     = $clog2(DIV_STEPS + 1);

    localparam logic [DBITS-1:0]  ONE  = DBITS'(1) << FRAC_BITS;
    localparam logic [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIV,
        S_MDEN,
        S_SUMDEN,
        S_MFR,
        S_MIP,
        S_MTOL,
        S_TEST,
        S_DONE
    } state_t;

endpackage

[rtl/core/continued_fraction_approximator_core.sv]
// Continued-fraction rational approximator: sequencer, shared divider and multiplier.
`timescale 1ns / 1ps

//  channel   direction  handshake               payload
//  input     in         in_valid / in_stall     value
//  result    out        out_valid / out_stall   numerator, denominator, is_fraction
//  config    in         cfg_write               cfg_data (tolerance)
//
// A whole value skips the divider and goes from S_DONE to the output register. A
// fraction runs Euclid steps, each a divide in S_DIV and then S_MDEN to S_TEST: one
// bit-serial restoring divider and one shared multiplier do all the arithmetic.
// Reset clears the sequencer, the output valid and sets tolerance to 1.
// in_stall is high while a word is in work; the next word is taken while a
// finished result still waits in the output register under out_stall.

module continued_fraction_approximator_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [cfa_pkg::VALUE_BITS-1:0] value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic signed [cfa_pkg::NUM_W-1:0]  numerator,
    output logic        [cfa_pkg::DEN_W-1:0]  denominator,
    output logic                              is_fraction,
    input  logic                              cfg_write,
    input  logic        [cfa_pkg::TOL_W-1:0]  cfg_data
);

    cfa_pkg::state_t state_reg, state_next;

    logic [cfa_pkg::CNT_W-1:0]  cnt_reg, cnt_next;
    logic [cfa_pkg::DBITS-1:0]  p_reg, p_next;
    logic [cfa_pkg::FR_W-1:0]   q_reg, q_next;
    logic [cfa_pkg::DBITS-1:0]  quo_reg, quo_next;
    logic [cfa_pkg::FR_W-1:0]   rm_reg, rm_next;
    logic [cfa_pkg::DBITS-1:0]  den_reg, den_next;
    logic [cfa_pkg::DBITS-1:0]  prev_reg, prev_next;
    logic [cfa_pkg::PROD_W-1:0] mul_reg, mul_next;
    logic [cfa_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [cfa_pkg::DBITS-1:0]  rnd_reg, rnd_next;
    logic [cfa_pkg::NUMI_W-1:0] num_reg, num_next;
    logic [cfa_pkg::PROD_W-1:0] err_reg, err_next;
    logic                       neg_reg, neg_next;
    logic [cfa_pkg::IP_W-1:0]   ip_reg, ip_next;
    logic [cfa_pkg::FR_W-1:0]   fr_reg, fr_next;
    logic                       frac_reg, frac_next;
    logic [cfa_pkg::TOL_W-1:0]  tol_reg;

    logic                             out_valid_reg, out_valid_next;
    logic signed [cfa_pkg::NUM_W-1:0] numerator_reg, numerator_next;
    logic [cfa_pkg::DEN_W-1:0]        denominator_reg, denominator_next;
    logic                             is_fraction_reg, is_fraction_next;

    // shared multiplier operands
    logic [cfa_pkg::MUL_W-1:0] mul_x, mul_y;

    logic                           accept;
    logic                           out_free;
    logic                           div_last;
    logic                           stop;
    logic [cfa_pkg::VALUE_BITS-1:0] mag;
    logic [cfa_pkg::DBITS-1:0]      trial;
    logic                           trial_ge;
    logic [cfa_pkg::FR_W-1:0]       rm_step;
    logic [cfa_pkg::PROD_W-1:0]     rnd_wide;
    logic [cfa_pkg::PROD_W-1:0]     rnd_sum;
    logic [cfa_pkg::NUMI_W-1:0]     num_signed;

    assign accept   = in_valid && (state_reg == cfa_pkg::S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign div_last = (cnt_reg == cfa_pkg::CNT_W'(1));
    assign stop     = (q_reg == '0) || (err_reg <= mul_reg);

    assign mag = value[cfa_pkg::VALUE_BITS-1]
               ? (cfa_pkg::VALUE_BITS'(0) - cfa_pkg::VALUE_BITS'(value))
               : cfa_pkg::VALUE_BITS'(value);

    // restoring divider, one quotient bit a cycle
    assign trial    = {rm_reg, quo_reg[cfa_pkg::DBITS-1]};
    assign trial_ge = (trial >= cfa_pkg::DBITS'(q_reg));
    assign rm_step  = trial_ge ? cfa_pkg::FR_W'(trial - cfa_pkg::DBITS'(q_reg))
                               : cfa_pkg::FR_W'(trial);

    assign rnd_sum    = mul_reg + cfa_pkg::HALF;
    assign rnd_wide   = cfa_pkg::PROD_W'(rnd_reg) << cfa_pkg::FRAC_BITS;
    assign num_signed = neg_reg ? (cfa_pkg::NUMI_W'(0) - num_reg) : num_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cfa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (mag[cfa_pkg::FRAC_BITS-1:0] == '0)
                        state_next = cfa_pkg::S_DONE;
                    else
                        state_next = cfa_pkg::S_DIV;
                end
            end
            cfa_pkg::S_DIV:
            begin
                if (div_last)
                    state_next = cfa_pkg::S_MDEN;
            end
            cfa_pkg::S_MDEN:   state_next = cfa_pkg::S_SUMDEN;
            cfa_pkg::S_SUMDEN: state_next = cfa_pkg::S_MFR;
            cfa_pkg::S_MFR:    state_next = cfa_pkg::S_MIP;
            cfa_pkg::S_MIP:    state_next = cfa_pkg::S_MTOL;
            cfa_pkg::S_MTOL:   state_next = cfa_pkg::S_TEST;
            cfa_pkg::S_TEST:
            begin
                if (stop)
                    state_next = cfa_pkg::S_DONE;
                else
                    state_next = cfa_pkg::S_DIV;
            end
            cfa_pkg::S_DONE:
            begin
                if (out_free)
                    state_next = cfa_pkg::S_IDLE;
            end
            default:           state_next = cfa_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next         = cnt_reg;
        p_next           = p_reg;
        q_next           = q_reg;
        quo_next         = quo_reg;
        rm_next          = rm_reg;
        den_next         = den_reg;
        prev_next        = prev_reg;
        prod_next        = prod_reg;
        rnd_next         = rnd_reg;
        num_next         = num_reg;
        err_next         = err_reg;
        neg_next         = neg_reg;
        ip_next          = ip_reg;
        fr_next          = fr_reg;
        frac_next        = frac_reg;
        mul_x            = '0;
        mul_y            = '0;
        out_valid_next   = out_valid_reg && out_stall;
        numerator_next   = numerator_reg;
        denominator_next = denominator_reg;
        is_fraction_next = is_fraction_reg;

        case (state_reg)
            cfa_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    neg_next  = value[cfa_pkg::VALUE_BITS-1];
                    ip_next   = mag[cfa_pkg::VALUE_BITS-1:cfa_pkg::FRAC_BITS];
                    fr_next   = mag[cfa_pkg::FRAC_BITS-1:0];
                    p_next    = cfa_pkg::ONE;
                    q_next    = mag[cfa_pkg::FRAC_BITS-1:0];
                    quo_next  = cfa_pkg::ONE;
                    rm_next   = '0;
                    cnt_next  = cfa_pkg::CNT_W'(cfa_pkg::DIV_STEPS);
                    den_next  = cfa_pkg::DBITS'(1);
                    prev_next = '0;
                    num_next  = cfa_pkg::NUMI_W'(mag[cfa_pkg::VALUE_BITS-1:cfa_pkg::FRAC_BITS]);
                    frac_next = 1'b0;
                end
            end
            cfa_pkg::S_DIV:
            begin
                quo_next = {quo_reg[cfa_pkg::DBITS-2:0], trial_ge};
                rm_next  = rm_step;
                cnt_next = cnt_reg - cfa_pkg::CNT_W'(1);
                if (div_last)
                begin
                    // Euclid shift: divisor becomes dividend, remainder the divisor
                    p_next = cfa_pkg::DBITS'(q_reg);
                    q_next = rm_step;
                end
            end
            cfa_pkg::S_MDEN:
            begin
                mul_x = cfa_pkg::MUL_W'(den_reg);
                mul_y = cfa_pkg::MUL_W'(quo_reg);
            end
            cfa_pkg::S_SUMDEN:
            begin
                den_next  = cfa_pkg::DBITS'(mul_reg) + prev_reg;
                prev_next = den_reg;
            end
            cfa_pkg::S_MFR:
            begin
                mul_x = cfa_pkg::MUL_W'(fr_reg);
                mul_y = cfa_pkg::MUL_W'(den_reg);
            end
            cfa_pkg::S_MIP:
            begin
                prod_next = mul_reg;
                rnd_next  = cfa_pkg::DBITS'(rnd_sum >> cfa_pkg::FRAC_BITS);
                mul_x     = cfa_pkg::MUL_W'(ip_reg);
                mul_y     = cfa_pkg::MUL_W'(den_reg);
            end
            cfa_pkg::S_MTOL:
            begin
                num_next = cfa_pkg::NUMI_W'(mul_reg) + cfa_pkg::NUMI_W'(rnd_reg);
                err_next = (prod_reg >= rnd_wide) ? (prod_reg - rnd_wide)
                                                  : (rnd_wide - prod_reg);
                mul_x    = cfa_pkg::MUL_W'(tol_reg);
                mul_y    = cfa_pkg::MUL_W'(den_reg);
            end
            cfa_pkg::S_TEST:
            begin
                if (stop)
                    frac_next = 1'b1;
                else
                begin
                    quo_next = p_reg;
                    rm_next  = '0;
                    cnt_next = cfa_pkg::CNT_W'(cfa_pkg::DIV_STEPS);
                end
            end
            cfa_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    numerator_next   = cfa_pkg::NUM_W'($signed(num_signed));
                    denominator_next = cfa_pkg::DEN_W'(den_reg);
                    is_fraction_next = frac_reg;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase

        mul_next = mul_x * mul_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cfa_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            tol_reg       <= cfa_pkg::TOL_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write)
                tol_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg         <= cnt_next;
        p_reg           <= p_next;
        q_reg           <= q_next;
        quo_reg         <= quo_next;
        rm_reg          <= rm_next;
        den_reg         <= den_next;
        prev_reg        <= prev_next;
        mul_reg         <= mul_next;
        prod_reg        <= prod_next;
        rnd_reg         <= rnd_next;
        num_reg         <= num_next;
        err_reg         <= err_next;
        neg_reg         <= neg_next;
        ip_reg          <= ip_next;
        fr_reg          <= fr_next;
        frac_reg        <= frac_next;
        numerator_reg   <= numerator_next;
        denominator_reg <= denominator_next;
        is_fraction_reg <= is_fraction_next;
    end

    assign in_stall    = (state_reg != cfa_pkg::S_IDLE);
    assign out_valid   = out_valid_reg;
    assign numerator   = numerator_reg;
    assign denominator = denominator_reg;
    assign is_fraction = is_fraction_reg;

endmodule

[tb/continued_fraction_approximator_core_tb.sv]
// Self-checking testbench for the continued-fraction rational approximator core.
`timescale 1ns / 1ps

module continued_fraction_approximator_core_tb;

    localparam int WATCHDOG_LIMIT = 8000;
    localparam int SETTLE_CYCLES  = 30;

    typedef struct packed {
        logic [cfa_pkg::NUM_W-1:0] num;
        logic [cfa_pkg::DEN_W-1:0] den;
        logic                      frac;
    } approx_t;

    typedef enum int {
        STALL_NONE,
        STALL_RANDOM,
        STALL_BURSTY
    } stall_mode_t;

    logic                                  clk = 1'b0;
    logic                                  rst_n = 1'b0;
    logic                                  in_valid = 1'b0;
    logic                                  in_stall;
    logic signed [cfa_pkg::VALUE_BITS-1:0] value = '0;
    logic                                  out_valid;
    logic                                  out_stall = 1'b0;
    logic signed [cfa_pkg::NUM_W-1:0]      numerator;
    logic        [cfa_pkg::DEN_W-1:0]      denominator;
    logic                                  is_fraction;
    logic                                  cfg_write = 1'b0;
    logic        [cfa_pkg::TOL_W-1:0]      cfg_data = '0;

    approx_t                   approx_q[$];
    logic [cfa_pkg::TOL_W-1:0] tolerance_now = cfa_pkg::TOL_RESET;
    int                        mismatches = 0;
    int                        quiet_cycles = 0;
    int                        burst_left = 0;
    bit                        gaps_on = 1'b1;
    stall_mode_t               stall_mode = STALL_RANDOM;
    int                        stall_run = 0;

    continued_fraction_approximator_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .numerator   (numerator),
        .denominator (denominator),
        .is_fraction (is_fraction),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Convergents of the fraction part until the remainder runs out or the
    // error falls within tolerance; the error test is exact in integers.
    function automatic approx_t approximate(
        input logic signed [cfa_pkg::VALUE_BITS-1:0] v,
        input logic [cfa_pkg::TOL_W-1:0] tol);
        logic [63:0] raw, mag, ip, fr, p, q, prev, den, num;
        logic [63:0] a, rmd, t, prod, rnd, err, tol64;
        bit          neg;
        bit          done;
        approx_t     r;
        raw = '0;
        raw[cfa_pkg::VALUE_BITS-1:0] = v;
        neg = v[cfa_pkg::VALUE_BITS-1];
        mag = neg ? ((64'd1 << cfa_pkg::VALUE_BITS) - raw) : raw;
        ip = mag >> cfa_pkg::FRAC_BITS;
        fr = mag & ((64'd1 << cfa_pkg::FRAC_BITS) - 64'd1);
        tol64 = '0;
        tol64[cfa_pkg::TOL_W-1:0] = tol;
        if (fr == 0)
        begin
            num = ip;
            den = 64'd1;
            r.frac = 1'b0;
        end
        else
        begin
            p = 64'd1 << cfa_pkg::FRAC_BITS;
            q = fr;
            prev = '0;
            den = 64'd1;
            num = '0;
            done = 1'b0;
            while (!done)
            begin
                a = p / q;
                rmd = p % q;
                t = den;
                den = den * a + prev;
                prev = t;
                prod = fr * den;
                rnd = (prod + (64'd1 << (cfa_pkg::FRAC_BITS - 1))) >> cfa_pkg::FRAC_BITS;
                num = ip * den + rnd;
                err = (prod >= (rnd << cfa_pkg::FRAC_BITS))
                    ? prod - (rnd << cfa_pkg::FRAC_BITS)
                    : (rnd << cfa_pkg::FRAC_BITS) - prod;
                p = q;
                q = rmd;
                done = (rmd == 0) || (err <= tol64 * den);
            end
            r.frac = 1'b1;
        end
        if (neg)
            num = 64'd0 - num;
        r.num = num[cfa_pkg::NUM_W-1:0];
        r.den = den[cfa_pkg::DEN_W-1:0];
        return r;
    endfunction

    // Offer one word, with random gaps between bursts when gaps_on is set; in_valid
    // stays high across words inside a burst.
    task automatic send_word(input logic signed [cfa_pkg::VALUE_BITS-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            gap = 0;
            if (gaps_on)
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 400)
                                                  : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
        approx_q.push_back(approximate(v, tolerance_now));
        burst_left--;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        while (approx_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_tolerance(input logic [cfa_pkg::TOL_W-1:0] tol);
        drain();
        repeat (4) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= tol;
        @(posedge clk);
        cfg_write <= 1'b0;
        tolerance_now = tol;
    endtask

    function automatic logic signed [cfa_pkg::VALUE_BITS-1:0] pick_value();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: return r & 32'hFFFF_0000;                              // whole
            1: return {r[31:16], 16'd1 << $urandom_range(0, 15)};    // short expansion
            2: return {r[31] ? 16'h8000 : 16'h7FFF, r[15:0]};        // near the extremes
            3: return {{13{r[31]}}, r[18:0]};                         // small magnitude
            4: return {r[31:16], 16'(65536 * $urandom_range(1, 6)
                                    / $urandom_range(7, 13))};        // simple ratios
            default: return r;
        endcase
    endfunction

    task automatic test_whole_values();
        send_word(32'sh0000_0000);
        send_word(32'sh0001_0000);
        send_word(32'shFFFF_0000);
        send_word(32'sh7FFF_0000);
        send_word(32'sh8000_0000);   // most negative value
        send_word(32'sh1234_0000);
    endtask

    task automatic test_fraction_extremes();
        send_word(32'sh0000_0001);
        send_word(32'shFFFF_FFFF);
        send_word(32'sh0000_FFFF);
        send_word(32'sh0000_8000);
        send_word(32'shFFFF_8000);
        send_word(32'sh7FFF_FFFF);
        send_word(32'sh8000_0001);
        send_word(32'sh0003_243F);
    endtask

    // zero tolerance gives the exact reduced fraction
    task automatic test_zero_tolerance();
        set_tolerance('0);
        send_word(32'sh0000_5555);
        send_word(32'sh0000_AAAB);
        send_word(32'sh0003_243F);
        send_word(32'shFFFC_DBC1);
        send_word(32'sh0000_0001);
        send_word(32'sh0000_7FFF);
    endtask

    // widest tolerance: the first convergent may already be a whole n/1
    task automatic test_max_tolerance();
        set_tolerance(16'hFFFF);
        send_word(32'sh0000_FFFF);
        send_word(32'sh0001_8000);
        send_word(32'shFFFF_0001);
        send_word(32'sh7FFF_FFFF);
        send_word(32'sh8000_0001);
    endtask

    task automatic test_drain_pause();
        set_tolerance(16'd3);
        repeat (5) send_word(pick_value());
        drain();
        repeat (5) send_word(pick_value());
    endtask

    task automatic test_random();
        logic [cfa_pkg::TOL_W-1:0] tol;
        for (int rnd_i = 0; rnd_i < 7; rnd_i++)
        begin
            case (rnd_i)
                0: tol = '0;
                1: tol = 16'd1;
                2: tol = 16'hFFFF;
                3: tol = cfa_pkg::TOL_W'($urandom_range(2, 20));
                4: tol = cfa_pkg::TOL_W'($urandom_range(100, 2000));
                default: tol = cfa_pkg::TOL_W'($urandom);
            endcase
            set_tolerance(tol);
            gaps_on = (rnd_i % 3) != 1;
            stall_mode = stall_mode_t'(rnd_i % 3);
            repeat (95) send_word(pick_value());
        end
    endtask

    always @(posedge clk)
    begin : check_results
        approx_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (approx_q.size() == 0)
            begin
                $error("result word with nothing pending: num=%0d den=%0d frac=%0b",
                       numerator, denominator, is_fraction);
                mismatches++;
            end
            else
            begin
                want = approx_q.pop_front();
                if (numerator !== want.num)
                begin
                    $error("numerator: expected %0d, got %0d",
                           $signed(want.num), numerator);
                    mismatches++;
                end
                if (denominator !== want.den)
                begin
                    $error("denominator: expected %0d, got %0d", want.den, denominator);
                    mismatches++;
                end
                if (is_fraction !== want.frac)
                begin
                    $error("is_fraction: expected %0b, got %0b", want.frac, is_fraction);
                    mismatches++;
                end
            end
        end
        case (stall_mode)
            STALL_NONE:   out_stall <= 1'b0;
            STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
            default:
            begin
                if (stall_run > 0)
                begin
                    stall_run--;
                    out_stall <= 1'b1;
                end
                else if ($urandom_range(0, 15) == 0)
                begin
                    stall_run = $urandom_range(5, 60);
                    out_stall <= 1'b1;
                end
                else
                    out_stall <= 1'b0;
            end
        endcase
    end

    initial
    begin : watchdog
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_whole_values();
        test_fraction_extremes();
        test_zero_tolerance();
        test_max_tolerance();
        test_drain_pause();
        test_random();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
